// ===== rtl/assert_macros.svh =====
// Assertion macros used by osad_ctrl.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OSAD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("osad assertion failed");
`define OSAD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("osad forbidden condition");
`else
`define OSAD_ASSERT(lbl, prop)
`define OSAD_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/osad_pkg.sv =====
// Types, constants and helpers for the online softmax attention decode block.
// Used by the controller, the datapath, the divider and the top level.
package osad_pkg;

  localparam int MAX_DIM_DEF = 64;

  localparam logic [15:0] SCALE_RST = 16'd8192;
  localparam logic [6:0]  DIM_RST   = 7'd64;

  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_DIM   = 1'b1;

  localparam logic [16:0] EXP_LOG2E = 17'd94548;
  localparam logic [15:0] EXP_C1    = 16'd43024;
  localparam logic [13:0] EXP_C2    = 14'd10256;
  localparam logic [16:0] EXP_ONE   = 17'd65536;

  localparam logic [5:0] DIV_STEPS = 6'd40;

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_KEY    = 2'd1,
    OP_VALUE  = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_K_MUL,
    S_K_ACC,
    S_SC_MUL,
    S_SC_SUM,
    S_MAX,
    S_EXP_O,
    S_EXP_N,
    S_EW1,
    S_EW2,
    S_SUM_MUL,
    S_SUM_UPD,
    S_V_MUL,
    S_V_WR,
    S_F_RD,
    S_F_DIV,
    S_F_WAIT,
    S_F_OUT
  } state_t;

  typedef struct packed {
    logic idle;
    logic accept;
    logic k_mul;
    logic k_acc;
    logic sc_mul;
    logic sc_sum;
    logic max_upd;
    logic exp_old;
    logic cap_wold;
    logic sum_mul;
    logic sum_upd;
    logic v_mul;
    logic v_wr;
    logic f_rd;
    logic div_start;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_in_d;
    logic k_last;
    logic div_done;
    logic walk_last;
    logic out_free;
  } st_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/osad_ctrl.sv =====
// Sequencing state machine for the attention decode block.
// Depends on osad_pkg and assert_macros.svh.
`include "assert_macros.svh"
module osad_ctrl import osad_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  st_t    st,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (st.op)
            OP_KEY:    state_nxt = st.idx_in_d ? S_K_MUL : S_IDLE;
            OP_VALUE:  state_nxt = st.idx_in_d ? S_V_MUL : S_IDLE;
            OP_FINISH: state_nxt = S_F_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_K_MUL:   state_nxt = S_K_ACC;
      S_K_ACC:   state_nxt = st.k_last ? S_SC_MUL : S_IDLE;
      S_SC_MUL:  state_nxt = S_SC_SUM;
      S_SC_SUM:  state_nxt = S_MAX;
      S_MAX:     state_nxt = S_EXP_O;
      S_EXP_O:   state_nxt = S_EXP_N;
      S_EXP_N:   state_nxt = S_EW1;
      S_EW1:     state_nxt = S_EW2;
      S_EW2:     state_nxt = S_SUM_MUL;
      S_SUM_MUL: state_nxt = S_SUM_UPD;
      S_SUM_UPD: state_nxt = S_IDLE;
      S_V_MUL:   state_nxt = S_V_WR;
      S_V_WR:    state_nxt = S_IDLE;
      S_F_RD:    state_nxt = S_F_DIV;
      S_F_DIV:   state_nxt = S_F_WAIT;
      S_F_WAIT:  state_nxt = st.div_done ? S_F_OUT : S_F_WAIT;
      S_F_OUT: begin
        if (st.out_free) begin
          state_nxt = st.walk_last ? S_IDLE : S_F_RD;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.idle   = 1'b1;
        cmd.accept = in_valid;
      end
      S_K_MUL:   cmd.k_mul = 1'b1;
      S_K_ACC:   cmd.k_acc = 1'b1;
      S_SC_MUL:  cmd.sc_mul = 1'b1;
      S_SC_SUM:  cmd.sc_sum = 1'b1;
      S_MAX:     cmd.max_upd = 1'b1;
      S_EXP_O:   cmd.exp_old = 1'b1;
      S_EW2:     cmd.cap_wold = 1'b1;
      S_SUM_MUL: cmd.sum_mul = 1'b1;
      S_SUM_UPD: cmd.sum_upd = 1'b1;
      S_V_MUL:   cmd.v_mul = 1'b1;
      S_V_WR:    cmd.v_wr = 1'b1;
      S_F_RD:    cmd.f_rd = 1'b1;
      S_F_DIV:   cmd.div_start = 1'b1;
      S_F_OUT: begin
        cmd.emit  = st.out_free;
        cmd.clear = st.out_free && st.walk_last;
      end
      default: cmd = '0;
    endcase
  end

  // The weight capture relies on the fixed latency of the exp pipeline.
  `OSAD_ASSERT(a_exp_timing, (state_r == S_EXP_O) |-> ##4 (state_r == S_SUM_MUL))
  `OSAD_ASSERT(a_div_restart, (state_r == S_F_DIV) |=> !st.div_done)
  `OSAD_ASSERT(a_emit_step, (state_r == S_F_OUT && st.out_free) |=> (state_r == S_F_RD || state_r == S_IDLE))
  `OSAD_NEVER(a_emit_only_free, cmd.emit && !st.out_free)

endmodule

// ===== rtl/osad_div.sv =====
// Restoring divider, one quotient bit per cycle, for the finish walk.
// Depends on osad_pkg.
module osad_div import osad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [31:0] divisor,
  output logic [39:0] quotient,
  output logic        done
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] div_r;
  logic [39:0] quo_r;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r, quo_r[39]};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_STEPS;
    end else if (busy_r && cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r && cnt_r != 6'd0) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, div_r}) : rem_sh[31:0];
      quo_r <= {quo_r[38:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = busy_r && cnt_r == 6'd0;

endmodule

// ===== rtl/osad_dp.sv =====
// Datapath: query and accumulator memories, dot product, exp pipeline,
// running max and sum, and the finish output register. Depends on osad_pkg
// and osad_div.
module osad_dp import osad_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_element_index,
  input  logic signed [15:0] in_element_value,
  input  logic [15:0]        score_scale,
  input  logic [6:0]         active_dim,
  input  logic               out_stall,
  input  cmd_t               cmd,
  output st_t                st,
  output logic               out_valid,
  output logic signed [15:0] out_element,
  output logic [5:0]         out_index,
  output logic               out_last
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [6:0] HD7 = 7'(MAX_DIM);

  logic [6:0] dim_w;
  assign dim_w = (active_dim == 7'd0) ? 7'd1 : ((active_dim > HD7) ? HD7 : active_dim);

  // Memories.
  logic signed [15:0] q_mem [MAX_DIM];
  logic signed [31:0] a_mem [MAX_DIM];
  logic [MAX_DIM-1:0] vld_r;
  logic signed [15:0] q_rd_r;
  logic signed [31:0] a_rd_r;
  logic               a_ok_r;
  logic [AW-1:0]      a_addr;
  logic [AW-1:0]      in_addr;

  // Latched item and walk.
  logic signed [15:0] val_r;
  logic [5:0]         idx_r;
  logic               k_last_r;
  logic [AW-1:0]      walk_r;

  // Running state.
  logic signed [39:0] dot_r;
  logic signed [31:0] rmax_r;
  logic [31:0]        rsum_r;
  logic [16:0]        wold_r;
  logic [16:0]        wnew_r;
  logic               seen_r;

  // Intermediates.
  logic signed [31:0] prod_r;
  logic signed [36:0] ph_r;
  logic [35:0]        pl_r;
  logic signed [63:0] sc_full;
  logic signed [31:0] score_r;
  logic signed [31:0] nmax_r;
  logic signed [32:0] exp_x;
  logic [32:0]        exp_t;
  logic [49:0]        e1_prod;
  logic [33:0]        e1_y_r;
  logic [31:0]        e2_ff;
  logic [31:0]        e2_a;
  logic               e2_zero_r;
  logic [4:0]         e2_n_r;
  logic [15:0]        e2_ffh_r;
  logic [15:0]        e2_a_r;
  logic [29:0]        e3_b;
  logic [17:0]        e3_p;
  logic [16:0]        e3_r;
  logic [48:0]        sprod_r;
  logic [33:0]        sum_w;
  logic signed [31:0] acc_val;
  logic signed [49:0] m1_r;
  logic signed [33:0] m2_r;
  logic signed [31:0] acc_new;
  logic [31:0]        mag;
  logic               neg_r;
  logic               zero_r;
  logic [39:0]        quo;
  logic               div_done;
  logic signed [15:0] res;

  logic               out_valid_r;
  logic signed [15:0] out_element_r;
  logic [5:0]         out_index_r;
  logic               out_last_r;

  assign in_addr = in_element_index[AW-1:0];
  assign a_addr  = cmd.accept ? in_addr : walk_r;
  assign acc_val = a_ok_r ? a_rd_r : 32'sd0;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_op == OP_QUERY && {1'b0, in_element_index} < HD7) begin
      q_mem[in_addr] <= in_element_value;
    end
    if (cmd.accept) begin
      q_rd_r <= q_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.v_wr) begin
      a_mem[idx_r[AW-1:0]] <= acc_new;
    end
    if (cmd.accept || cmd.f_rd) begin
      a_rd_r <= a_mem[a_addr];
      a_ok_r <= vld_r[a_addr];
    end
  end

  // Valid bits stand in for clearing the accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r <= '0;
    end else if (cmd.v_wr) begin
      vld_r[idx_r[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r    <= in_element_value;
      idx_r    <= in_element_index;
      k_last_r <= {1'b0, in_element_index} == dim_w - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= '0;
    end else if (cmd.accept) begin
      walk_r <= '0;
    end else if (cmd.emit) begin
      walk_r <= walk_r + 1'b1;
    end
  end

  // Score: the 40-bit dot product is split into two partial products.
  assign sc_full = (64'(ph_r) <<< 20) + 64'($signed({1'b0, pl_r}));

  always_ff @(posedge clk) begin
    if (cmd.k_mul) begin
      prod_r <= q_rd_r * val_r;
    end
    if (cmd.sc_mul) begin
      ph_r <= $signed(dot_r[39:20]) * $signed({1'b0, score_scale});
      pl_r <= dot_r[19:0] * score_scale;
    end
    if (cmd.sc_sum) begin
      score_r <= sat32(sc_full >>> 16);
    end
    if (cmd.max_upd) begin
      nmax_r <= (seen_r && rmax_r > score_r) ? rmax_r : score_r;
    end
  end

  // Exp pipeline, three stages, always advancing.
  assign exp_x   = cmd.exp_old ? (33'(rmax_r) - 33'(nmax_r)) : (33'(score_r) - 33'(nmax_r));
  assign exp_t   = 33'(-exp_x);
  assign e1_prod = 50'(exp_t) * 50'(EXP_LOG2E);
  assign e2_ff   = 32'(e1_y_r[15:0]) * 32'(e1_y_r[15:0]);
  assign e2_a    = 32'(e1_y_r[15:0]) * 32'(EXP_C1);
  assign e3_b    = 30'(e2_ffh_r) * 30'(EXP_C2);
  assign e3_p    = 18'(EXP_ONE) - 18'(e2_a_r) + 18'(e3_b[29:16]);

  always_ff @(posedge clk) begin
    e1_y_r    <= e1_prod[49:16];
    e2_zero_r <= e1_y_r[33:16] > 18'd16;
    e2_n_r    <= e1_y_r[20:16];
    e2_ffh_r  <= e2_ff[31:16];
    e2_a_r    <= e2_a[31:16];
    e3_r      <= e2_zero_r ? 17'd0 : 17'(e3_p >> e2_n_r);
  end

  assign sum_w = 34'(sprod_r[48:16]) + 34'(wnew_r);

  always_ff @(posedge clk) begin
    if (cmd.sum_mul) begin
      sprod_r <= 49'(rsum_r) * 49'(wold_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      dot_r  <= '0;
      rmax_r <= '0;
      rsum_r <= '0;
      wold_r <= '0;
      wnew_r <= '0;
      seen_r <= 1'b0;
    end else begin
      if (cmd.k_acc) begin
        dot_r <= dot_r + 40'(prod_r);
      end
      if (cmd.cap_wold) begin
        wold_r <= seen_r ? e3_r : 17'd0;
      end
      if (cmd.sum_mul) begin
        wnew_r <= e3_r;
      end
      if (cmd.sum_upd) begin
        rsum_r <= (sum_w[33:32] != 2'd0) ? 32'hFFFF_FFFF : sum_w[31:0];
        rmax_r <= nmax_r;
        seen_r <= 1'b1;
        dot_r  <= '0;
      end
    end
  end

  // Value update.
  assign acc_new = sat32(64'(m1_r >>> 16) + 64'(m2_r >>> 8));

  always_ff @(posedge clk) begin
    if (cmd.v_mul) begin
      m1_r <= 50'(acc_val) * 50'($signed({1'b0, wold_r}));
      m2_r <= 34'(val_r) * 34'($signed({1'b0, wnew_r}));
    end
  end

  // Finish: divide the magnitude, then restore the sign with saturation.
  assign mag = acc_val[31] ? (32'(~acc_val) + 32'd1) : 32'(acc_val);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r  <= acc_val[31];
      zero_r <= !seen_r || rsum_r == 32'd0;
    end
  end

  osad_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({mag, 8'd0}),
    .divisor  (rsum_r),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    if (zero_r) begin
      res = 16'sd0;
    end else if (neg_r) begin
      res = (quo > 40'd32768) ? 16'sh8000 : $signed(16'(-quo[15:0]));
    end else begin
      res = (quo > 40'd32767) ? 16'sh7fff : $signed(quo[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_element_r <= res;
      out_index_r   <= 6'(walk_r);
      out_last_r    <= st.walk_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_element = out_element_r;
  assign out_index   = out_index_r;
  assign out_last    = out_last_r;

  assign st.op        = op_t'(in_op);
  assign st.idx_in_d  = {1'b0, in_element_index} < dim_w;
  assign st.k_last    = k_last_r;
  assign st.div_done  = div_done;
  assign st.walk_last = 7'(walk_r) == dim_w - 7'd1;
  assign st.out_free  = !out_valid_r || !out_stall;

endmodule

// ===== rtl/online_softmax_attention_decode.sv =====
// Single-query, single-head attention with an online softmax. Items are
// taken one at a time: a query item or an ignored item is taken without
// stalling the input, a key item that does not end a token holds the input
// for its multiply and accumulate, the key item that ends a token also goes
// through the score multiply, the shared exp pipeline and the sum update,
// and a value item holds it for its multiply and write. A finish item walks
// the accumulators; for each result element: a read, a divider start, the
// one-bit-per-cycle 40-step divider and the output load, which waits for a
// free output register; the input is stalled until the last element has
// been loaded into the output register. Depends on osad_pkg, osad_ctrl, osad_dp.
module online_softmax_attention_decode import osad_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [5:0]         in_element_index,
  input  logic signed [15:0] in_element_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_element,
  output logic [5:0]         out_index,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] score_scale_r;
  logic [6:0]  active_dim_r;
  cmd_t        cmd;
  st_t         st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_scale_r <= SCALE_RST;
      active_dim_r  <= DIM_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SCALE: score_scale_r <= pwdata[15:0];
        REG_DIM:   active_dim_r  <= pwdata[6:0];
        default:   score_scale_r <= score_scale_r;
      endcase
    end
  end

  assign prdata   = (paddr[2] == REG_DIM) ? {25'd0, active_dim_r} : {16'd0, score_scale_r};
  assign pready   = 1'b1;
  assign in_stall = !cmd.idle;

  osad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd)
  );

  osad_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .score_scale      (score_scale_r),
    .active_dim       (active_dim_r),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_element      (out_element),
    .out_index        (out_index),
    .out_last         (out_last)
  );

endmodule
